### rtl/core/plir_pkg.sv
// Shared types and constants for the positional list insert/remove block.
package plir_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int POS_W            = 8;
   localparam int VAL_W            = 32;
   localparam int LEN_W            = 7;
   localparam int GROUP            = 8;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_POS = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic                     cmd;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [VAL_W-1:0]  removed_value;
      logic [LEN_W-1:0]         list_length;
   } rsp_type;

   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [POS_W-1:0] idx;
   } shift_ctl_type;

endpackage

### rtl/core/plir_cell.sv
// One list cell: holds an element and shifts to or from its neighbours.
module plir_cell #(
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  plir_pkg::shift_ctl_type        ctl,
   input  logic signed [plir_pkg::VAL_W-1:0] new_value,
   input  logic signed [plir_pkg::VAL_W-1:0] prev_value,
   input  logic signed [plir_pkg::VAL_W-1:0] next_value,
   output logic signed [plir_pkg::VAL_W-1:0] value,
   output logic signed [plir_pkg::VAL_W-1:0] tap
);

   localparam logic [plir_pkg::POS_W-1:0] MY_IDX = plir_pkg::POS_W'(INDEX);

   logic signed [plir_pkg::VAL_W-1:0] value_ff, value_in;
   logic signed [plir_pkg::VAL_W-1:0] tap_ff, tap_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins && MY_IDX > ctl.idx) begin
         value_in = prev_value;
      end else if (ctl.ins && MY_IDX == ctl.idx) begin
         value_in = new_value;
      end else if (ctl.rem && MY_IDX >= ctl.idx) begin
         value_in = next_value;
      end
      tap_in = (ctl.rem && MY_IDX == ctl.idx) ? value_ff : '0;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tap_ff   <= tap_in;
   end

   assign value = value_ff;
   assign tap   = tap_ff;

endmodule

### rtl/core/plir_merge.sv
// Registered first level of the OR tree that gathers the removed word.
module plir_merge #(
   parameter int N = plir_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic signed [plir_pkg::VAL_W-1:0] taps [N],
   output logic signed [plir_pkg::VAL_W-1:0] partials [(N + plir_pkg::GROUP - 1) / plir_pkg::GROUP]
);

   localparam int G = (N + plir_pkg::GROUP - 1) / plir_pkg::GROUP;

   logic signed [plir_pkg::VAL_W-1:0] part_ff [G];
   logic signed [plir_pkg::VAL_W-1:0] part_in [G];

   always_comb begin
      for (int g = 0; g < G; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < plir_pkg::GROUP; k++) begin
            if (g * plir_pkg::GROUP + k < N) begin
               part_in[g] = part_in[g] | taps[g * plir_pkg::GROUP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

   assign partials = part_ff;

endmodule

### rtl/core/positional_list_insert_remove_top.sv
// Top level of the positional list insert/remove block.
// The list lives in a row of CAPACITY cells, element 1 in cell 0; an insert or
// remove moves every affected cell in the same cycle the word is accepted. The
// result word passes the cell taps, the first OR level and the response register,
// and one word is in flight at a time, so a new word is taken only after the
// previous result has left the result side. The removed element is collected
// from the cells by the OR tree, whose first level is registered in plir_merge.
module positional_list_insert_remove_top #(
   parameter int CAPACITY = plir_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plir_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plir_pkg::rsp_type rsp_word
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int G     = (CAPACITY + plir_pkg::GROUP - 1) / plir_pkg::GROUP;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             v1_ff, v1_in, v2_ff, v2_in, rsp_valid_ff, rsp_valid_in;
   logic [1:0]       st1_ff, st2_ff, status_in;
   logic [plir_pkg::LEN_W-1:0] len1_ff, len2_ff, len_in;
   plir_pkg::rsp_type rsp_ff, rsp_in;
   plir_pkg::shift_ctl_type ctl;

   logic signed [plir_pkg::VAL_W-1:0] vals  [CAPACITY];
   logic signed [plir_pkg::VAL_W-1:0] taps  [CAPACITY];
   logic signed [plir_pkg::VAL_W-1:0] parts [G];
   logic signed [plir_pkg::VAL_W-1:0] gathered;

   logic        accept;
   logic [8:0]  pos_x, cnt_x;
   logic [31:0] cnt_wide;

   assign req_stall = v1_ff | v2_ff | rsp_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign pos_x     = {1'b0, req_word.position};
   assign cnt_x     = 9'(count_ff);

   always_comb begin
      status_in = plir_pkg::ST_OK;
      count_in  = count_ff;
      ctl       = '0;
      if (accept) begin
         if (req_word.cmd == plir_pkg::CMD_INSERT) begin
            if (32'(count_ff) >= 32'(CAPACITY)) begin
               status_in = plir_pkg::ST_FULL;
            end else if (pos_x == 9'd0 || pos_x > cnt_x + 9'd1) begin
               status_in = plir_pkg::ST_BAD_POS;
            end else begin
               ctl.ins  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (count_ff == '0) begin
               status_in = plir_pkg::ST_EMPTY;
            end else if (pos_x == 9'd0 || pos_x > cnt_x) begin
               status_in = plir_pkg::ST_BAD_POS;
            end else begin
               ctl.rem  = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ctl.idx = req_word.position - plir_pkg::POS_W'(1);
      end
      cnt_wide = 32'(count_in);
      len_in   = cnt_wide[plir_pkg::LEN_W-1:0];
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [plir_pkg::VAL_W-1:0] prev_v, next_v;
      if (i == 0) begin : g_first
         assign prev_v = '0;
      end else begin : g_mid
         assign prev_v = vals[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_v = '0;
      end else begin : g_body
         assign next_v = vals[i+1];
      end
      plir_cell #(.INDEX(i)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_value  (req_word.value),
         .prev_value (prev_v),
         .next_value (next_v),
         .value      (vals[i]),
         .tap        (taps[i])
      );
   end

   plir_merge #(.N(CAPACITY)) u_merge (
      .clock    (clock),
      .taps     (taps),
      .partials (parts)
   );

   always_comb begin
      gathered = '0;
      for (int g = 0; g < G; g++) begin
         gathered = gathered | parts[g];
      end
   end

   always_comb begin
      v1_in        = accept;
      v2_in        = v1_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      if (v2_ff) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = st2_ff;
         rsp_in.removed_value = gathered;
         rsp_in.list_length   = len2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         st1_ff  <= status_in;
         len1_ff <= len_in;
      end
      if (v1_ff) begin
         st2_ff  <= st1_ff;
         len2_ff <= len1_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("word accepted while another is in flight");
   a_pipe_step: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff && !v1_ff)
      else $error("pipeline valid lost");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("count exceeds capacity");
   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != plir_pkg::ST_OK |-> rsp_ff.removed_value == '0)
      else $error("removed word non-zero on failed operation");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for the positional list insert/remove block.
`timescale 1ns / 1ps

module tb_top;
   import plir_pkg::*;

   localparam int CAP   = CAPACITY_DEFAULT;
   localparam int LIMIT = 200000;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type exp;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   logic signed [VAL_W-1:0] list_mem [CAP];
   int                      list_len;
   rsp_type                 pending_rsp [$];
   dir_row_type             dir_rows [$];
   int                      errors;
   int                      cycles;
   bit                      gap_on;
   int                      stall_pct;

   positional_list_insert_remove_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type list_apply(req_type w);
      rsp_type r;
      int      p;
      r.status        = ST_OK;
      r.removed_value = '0;
      p = int'(w.position);
      if (w.cmd == CMD_INSERT) begin
         if (list_len >= CAP) begin
            r.status = ST_FULL;
         end else if (p < 1 || p > list_len + 1) begin
            r.status = ST_BAD_POS;
         end else begin
            for (int i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
            list_mem[p-1] = w.value;
            list_len++;
         end
      end else begin
         if (list_len == 0) begin
            r.status = ST_EMPTY;
         end else if (p < 1 || p > list_len) begin
            r.status = ST_BAD_POS;
         end else begin
            r.removed_value = list_mem[p-1];
            for (int i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
         end
      end
      r.list_length = list_len[LEN_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gap_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic add_row(input logic c, input int p, input logic [VAL_W-1:0] v,
                          input bit t, input logic [1:0] s,
                          input logic [VAL_W-1:0] rv, input int len);
      dir_row_type row;
      row.word.cmd           = c;
      row.word.position      = p[POS_W-1:0];
      row.word.value         = v;
      row.typed              = t;
      row.exp.status         = s;
      row.exp.removed_value  = rv;
      row.exp.list_length    = len[LEN_W-1:0];
      dir_rows.push_back(row);
   endtask

   // one word per call; the prediction is taken at the accepting edge
   task automatic send_word(input req_type w, input bit typed, input rsp_type exp);
      rsp_type p;
      int      gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      p = list_apply(w);
      pending_rsp.push_back(typed ? exp : p);
   endtask

   initial begin
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected word: exp none, got status %0d removed %0d length %0d",
                     $time, rsp_word.status, rsp_word.removed_value, rsp_word.list_length);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_word.status !== e.status) begin
               $display("%0t status: exp %0d got %0d", $time, e.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.removed_value !== e.removed_value) begin
               $display("%0t removed_value: exp %0d got %0d", $time,
                        e.removed_value, rsp_word.removed_value);
               errors++;
            end
            if (rsp_word.list_length !== e.list_length) begin
               $display("%0t list_length: exp %0d got %0d", $time,
                        e.list_length, rsp_word.list_length);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      req_type w;
      rsp_type none;
      bit      fill;
      int      ins_pct;
      int      lim;
      int      r;
      errors    = 0;
      cycles    = 0;
      list_len  = 0;
      gap_on    = 1'b1;
      stall_pct = 30;
      none      = '0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;

      //      cmd         pos  value         typed status      removed       len
      add_row(CMD_REMOVE, 1,   32'd0,        1, ST_EMPTY,   32'd0,        0);
      add_row(CMD_INSERT, 0,   32'd5,        1, ST_BAD_POS, 32'd0,        0);
      add_row(CMD_INSERT, 2,   32'd5,        1, ST_BAD_POS, 32'd0,        0);
      add_row(CMD_INSERT, 1,   32'h80000000, 1, ST_OK,      32'd0,        1);
      add_row(CMD_REMOVE, 0,   32'd0,        1, ST_BAD_POS, 32'd0,        1);
      add_row(CMD_REMOVE, 2,   32'd0,        1, ST_BAD_POS, 32'd0,        1);
      add_row(CMD_REMOVE, 1,   32'hFFFFFFFF, 1, ST_OK,      32'h80000000, 0);
      add_row(CMD_REMOVE, 1,   32'd0,        1, ST_EMPTY,   32'd0,        0);
      add_row(CMD_INSERT, 1,   32'h7FFFFFFF, 1, ST_OK,      32'd0,        1);
      add_row(CMD_INSERT, 2,   32'hFFFFFFFF, 1, ST_OK,      32'd0,        2);
      add_row(CMD_INSERT, 1,   32'd0,        0, ST_OK,      32'd0,        0);
      add_row(CMD_INSERT, 4,   32'd12345,    0, ST_OK,      32'd0,        0);
      add_row(CMD_INSERT, 255, 32'd7,        1, ST_BAD_POS, 32'd0,        4);
      add_row(CMD_REMOVE, 255, 32'd0,        1, ST_BAD_POS, 32'd0,        4);
      add_row(CMD_INSERT, 3,   32'h55555555, 0, ST_OK,      32'd0,        0);
      add_row(CMD_INSERT, 2,   32'hAAAAAAAA, 0, ST_OK,      32'd0,        0);
      add_row(CMD_REMOVE, 2,   32'd0,        0, ST_OK,      32'd0,        0);
      add_row(CMD_REMOVE, 5,   32'd0,        0, ST_OK,      32'd0,        0);
      add_row(CMD_REMOVE, 1,   32'd0,        0, ST_OK,      32'd0,        0);
      add_row(CMD_REMOVE, 0,   32'd0,        0, ST_OK,      32'd0,        0);
      add_row(CMD_INSERT, 5,   32'd99,       0, ST_OK,      32'd0,        0);
      add_row(CMD_INSERT, 4,   32'd98,       0, ST_OK,      32'd0,        0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].exp);

      // alternate filling and draining so that both the full and empty ends are hit
      for (int n = 0; n < 390; n++) begin
         if (n % 50 == 0) begin
            gap_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 2);
            stall_pct = (r == 0) ? 0 : (r == 1) ? 30 : 70;
         end
         fill    = ((n / 130) % 2 == 0);
         ins_pct = fill ? 92 : 8;
         w.cmd   = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
         lim     = (w.cmd == CMD_INSERT) ? list_len + 1 : list_len;
         r       = $urandom_range(0, 99);
         if (r < 88)      w.position = (lim < 1) ? 8'd1 : POS_W'($urandom_range(1, lim));
         else if (r < 91) w.position = '0;
         else if (r < 94) w.position = '1;
         else if (r < 97) w.position = POS_W'(lim + 1);
         else             w.position = POS_W'($urandom_range(0, 255));
         r = $urandom_range(0, 9);
         if (r == 0)      w.value = {1'b1, {(VAL_W-1){1'b0}}};
         else if (r == 1) w.value = {1'b0, {(VAL_W-1){1'b1}}};
         else if (r == 2) w.value = '1;
         else             w.value = $urandom;
         send_word(w, 1'b0, none);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/plir_pkg.sv
rtl/core/plir_cell.sv
rtl/core/plir_merge.sv
rtl/core/positional_list_insert_remove_top.sv
test/tb_top.sv
